// ===== rtl/core/rjb_pkg.sv =====
// Shared types and constants of the RTP reorder jitter buffer.
`timescale 1ns / 1ps

package rjb_pkg;

  // Shortest packet that is still processed, in bytes.
  localparam logic [15:0] MinBytes = 16'd12;

  // Most packets released for one arriving packet.
  localparam int unsigned MaxResults = 32;
  localparam int unsigned RelCntW = $clog2(MaxResults + 1);

  // Width of the slot field of a result.
  localparam int unsigned OutSlotW = 5;

  // Shift of the fixed-point reciprocal used to take a sequence number modulo the depth.
  localparam int unsigned ModShift = 24;

  typedef enum logic [1:0] {
    STATUS_STORED   = 2'd0,
    STATUS_RELEASED = 2'd1,
    STATUS_TOO_OLD  = 2'd2,
    STATUS_SHORT    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_EXP,
    S_SEQ_SLOT,
    S_DECIDE,
    S_FINAL,
    S_READ,
    S_CHECK
  } state_e;

  // Commands from the controller to the slot store.
  typedef struct packed {
    logic wr_en;    // store a sequence number and set its valid mark
    logic clr_all;  // clear every valid mark
    logic rd_en;    // read one slot, data registered
    logic rel_en;   // clear the valid mark of a released slot
  } store_cmd_t;

endpackage

// ===== rtl/core/rjb_slot_mod.sv =====
// Two-stage unit that takes a 16-bit sequence number modulo the buffer depth.
`timescale 1ns / 1ps

module rjb_slot_mod #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic [15:0]              x_i,
  output logic [$clog2(DEPTH)-1:0] r_o
);

  localparam int unsigned SlotW = $clog2(DEPTH);
  localparam longint unsigned RecipL = ((64'd1 << rjb_pkg::ModShift) + DEPTH - 1) / DEPTH;
  localparam logic [23:0] Recip = 24'(RecipL);
  localparam logic [6:0] DepthC = 7'(DEPTH);

  logic [39:0] prod_d, prod_q;
  logic [15:0] x_q;
  logic [15:0] quot;
  logic [22:0] back;
  logic [15:0] rem;
  logic [SlotW-1:0] r_d, r_q;

  // The ceiling reciprocal gives the exact quotient for every 16-bit input.
  assign prod_d = {24'd0, x_i} * {16'd0, Recip};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x_q    <= x_i;
  end

  assign quot = prod_q[39:24];
  assign back = {7'd0, quot} * {16'd0, DepthC};
  assign rem  = x_q - back[15:0];
  assign r_d  = rem[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign r_o = r_q;

endmodule

// ===== rtl/core/rjb_slot_store.sv =====
// Slot store: sequence-number memory with registered read and per-slot valid marks.
`timescale 1ns / 1ps

module rjb_slot_store #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rjb_pkg::store_cmd_t      cmd_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [15:0]              wr_seq_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [15:0]              rd_seq_o,
  output logic                     rd_valid_o
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_d, valid_q;
  logic [15:0]      rd_seq_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_seq_i;
    end
    if (cmd_i.rd_en) begin
      rd_seq_q   <= mem[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // A release clears the slot that was just read; the read address still points at it.
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clr_all) begin
      valid_d = '0;
    end
    if (cmd_i.wr_en) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (cmd_i.rel_en) begin
      valid_d[rd_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_seq_o   = rd_seq_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== rtl/core/rtp_reorder_jitter_buffer.sv =====
// Top level of the RTP reorder jitter buffer: sequencer, counters and result register.
`timescale 1ns / 1ps

// Usage. Each transaction on the slave stream describes one arriving RTP packet:
// s_axis_tdata carries the sequence number and the packet length in bytes. For
// every packet the block returns one or more result transactions on the master
// stream, the final one marked by m_axis_tlast. A result either releases one
// stored packet in sequence order (m_axis_tuser says released, tdata carries the
// sequence and the slot that addresses its payload elsewhere) or reports that the
// packet was stored, dropped as too old or ignored as too short. Running drop and
// out-of-order counts ride along on every result.
// Sequencing: the sequence number and the expected sequence each pass the
// two-stage modulo unit before the decision in S_DECIDE. A short or too-old
// packet then passes S_FINAL, which loads its result. A stored packet probes
// the slot memory, which has a registered read, with S_READ and S_CHECK once
// per probe, and releases at most 32 packets.
// The slave side is ready only while the sequencer is idle. Results leave through
// an output register, so the next packet is accepted while the last result waits;
// a stalled master side holds the sequencer only when another result must go out.
// Reset clears all valid marks, both counters and the expected sequence (to zero).
// A write on the configuration port loads the expected sequence; write only while idle.
module rtp_reorder_jitter_buffer #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // initial_sequence

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] seq_number, [31:16] packet_bytes

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [15:0] release_seq, [20:16] release_slot,
                                      // [21] resynced, [53:22] dropped_total,
                                      // [85:54] out_of_order_total, [87:86] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);

  localparam int unsigned SlotW = $clog2(DEPTH);
  localparam logic signed [16:0] HalfPos = 17'(DEPTH / 2);
  localparam logic signed [16:0] HalfNeg = -HalfPos;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(DEPTH - 1);
  localparam logic [rjb_pkg::RelCntW-1:0] MaxRel = rjb_pkg::RelCntW'(rjb_pkg::MaxResults);

  rjb_pkg::state_e state_d, state_q;

  logic [15:0] seq_d, seq_q;
  logic        short_d, short_q;
  logic [SlotW-1:0] seq_slot_d, seq_slot_q;
  logic [15:0] exp_d, exp_q;
  logic [SlotW-1:0] exp_slot_d, exp_slot_q;
  logic        resync_d, resync_q;
  logic [31:0] drop_d, drop_q;
  logic [31:0] reord_d, reord_q;
  logic [rjb_pkg::RelCntW-1:0] n_d, n_q;
  logic        pend_d, pend_q;
  logic [15:0] pend_seq_d, pend_seq_q;
  logic [SlotW-1:0] pend_slot_d, pend_slot_q;
  rjb_pkg::status_e final_d, final_q;

  logic        out_valid_d, out_valid_q;
  rjb_pkg::status_e out_status_d, out_status_q;
  logic [15:0] out_seq_d, out_seq_q;
  logic [rjb_pkg::OutSlotW-1:0] out_slot_d, out_slot_q;
  logic        out_resync_d, out_resync_q;
  logic [31:0] out_drop_d, out_drop_q;
  logic [31:0] out_reord_d, out_reord_q;
  logic        out_last_d, out_last_q;

  logic [15:0] mod_in;
  logic [SlotW-1:0] mod_r;
  rjb_pkg::store_cmd_t cmd;
  logic [15:0] rd_seq;
  logic        rd_valid;

  logic [15:0] raw_diff;
  logic signed [16:0] diff;
  logic        too_old, need_resync, hit, out_free;

  // The modulo unit sees the new sequence number in the accept cycle, the expected
  // sequence in the next; both results pass its product and result registers.
  assign mod_in = (state_q == rjb_pkg::S_IDLE) ? s_axis_tdata[15:0] : exp_q;

  rjb_slot_mod #(
    .DEPTH(DEPTH)
  ) u_mod (
    .clk_i(clk_i),
    .x_i  (mod_in),
    .r_o  (mod_r)
  );

  rjb_slot_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (seq_slot_q),
    .wr_seq_i  (seq_q),
    .rd_addr_i (exp_slot_q),
    .rd_seq_o  (rd_seq),
    .rd_valid_o(rd_valid)
  );

  assign raw_diff    = seq_q - exp_q;
  assign diff        = {raw_diff[15], raw_diff};
  assign too_old     = diff < HalfNeg;
  assign need_resync = diff > HalfPos;
  assign hit         = rd_valid && (rd_seq == exp_q) && (n_q != MaxRel);
  assign out_free    = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    seq_d        = seq_q;
    short_d      = short_q;
    seq_slot_d   = seq_slot_q;
    exp_d        = exp_q;
    exp_slot_d   = exp_slot_q;
    resync_d     = resync_q;
    drop_d       = drop_q;
    reord_d      = reord_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_seq_d   = pend_seq_q;
    pend_slot_d  = pend_slot_q;
    final_d      = final_q;
    cmd          = '0;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_seq_d    = out_seq_q;
    out_slot_d   = out_slot_q;
    out_resync_d = out_resync_q;
    out_drop_d   = out_drop_q;
    out_reord_d  = out_reord_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      rjb_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          seq_d    = s_axis_tdata[15:0];
          short_d  = s_axis_tdata[31:16] < rjb_pkg::MinBytes;
          resync_d = 1'b0;
          n_d      = '0;
          pend_d   = 1'b0;
          state_d  = rjb_pkg::S_MOD_EXP;
        end
      end
      rjb_pkg::S_MOD_EXP: begin
        state_d = rjb_pkg::S_SEQ_SLOT;
      end
      rjb_pkg::S_SEQ_SLOT: begin
        seq_slot_d = mod_r;
        state_d    = rjb_pkg::S_DECIDE;
      end
      rjb_pkg::S_DECIDE: begin
        // The modulo unit now holds the slot of the expected sequence.
        exp_slot_d = mod_r;
        if (short_q) begin
          final_d = rjb_pkg::STATUS_SHORT;
          state_d = rjb_pkg::S_FINAL;
        end else if (too_old) begin
          drop_d  = drop_q + 32'd1;
          final_d = rjb_pkg::STATUS_TOO_OLD;
          state_d = rjb_pkg::S_FINAL;
        end else begin
          cmd.wr_en = 1'b1;
          if (need_resync) begin
            // Jump to the new sequence; the packet itself becomes the expected one.
            exp_d       = seq_q;
            exp_slot_d  = seq_slot_q;
            cmd.clr_all = 1'b1;
            drop_d      = drop_q + 32'd1;
            resync_d    = 1'b1;
          end else if (diff > 17'sd0) begin
            reord_d = reord_q + 32'd1;
          end
          state_d = rjb_pkg::S_READ;
        end
      end
      rjb_pkg::S_FINAL: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = final_q;
          out_seq_d    = '0;
          out_slot_d   = '0;
          out_resync_d = 1'b0;
          out_drop_d   = drop_q;
          out_reord_d  = reord_q;
          out_last_d   = 1'b1;
          state_d      = rjb_pkg::S_IDLE;
        end
      end
      rjb_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_d   = rjb_pkg::S_CHECK;
      end
      rjb_pkg::S_CHECK: begin
        // A release is held back one probe so that its last flag is known
        // when it goes out.
        if (hit) begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_valid_d  = 1'b1;
              out_status_d = rjb_pkg::STATUS_RELEASED;
              out_seq_d    = pend_seq_q;
              out_slot_d   = rjb_pkg::OutSlotW'(pend_slot_q);
              out_resync_d = resync_q;
              out_drop_d   = drop_q;
              out_reord_d  = reord_q;
              out_last_d   = 1'b0;
            end
            cmd.rel_en  = 1'b1;
            pend_d      = 1'b1;
            pend_seq_d  = exp_q;
            pend_slot_d = exp_slot_q;
            n_d         = n_q + rjb_pkg::RelCntW'(1);
            exp_d       = exp_q + 16'd1;
            // The sequence wrap restarts the slot count at zero as well.
            exp_slot_d  = (exp_slot_q == LastSlot || exp_q == 16'hFFFF) ? '0 :
                          exp_slot_q + SlotW'(1);
            state_d     = rjb_pkg::S_READ;
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_q ? rjb_pkg::STATUS_RELEASED : rjb_pkg::STATUS_STORED;
          out_seq_d    = pend_q ? pend_seq_q : '0;
          out_slot_d   = pend_q ? rjb_pkg::OutSlotW'(pend_slot_q) : '0;
          out_resync_d = resync_q;
          out_drop_d   = drop_q;
          out_reord_d  = reord_q;
          out_last_d   = 1'b1;
          pend_d       = 1'b0;
          state_d      = rjb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rjb_pkg::S_IDLE;
      end
    endcase

    // A configuration write loads exp_q; the user must keep it to idle; unchecked.
    if (cfg_we_i) begin
      exp_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rjb_pkg::S_IDLE;
      exp_q       <= '0;
      drop_q      <= '0;
      reord_q     <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      resync_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      drop_q      <= drop_d;
      reord_q     <= reord_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      resync_q    <= resync_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    short_q      <= short_d;
    seq_slot_q   <= seq_slot_d;
    exp_slot_q   <= exp_slot_d;
    pend_seq_q   <= pend_seq_d;
    pend_slot_q  <= pend_slot_d;
    final_q      <= final_d;
    out_status_q <= out_status_d;
    out_seq_q    <= out_seq_d;
    out_slot_q   <= out_slot_d;
    out_resync_q <= out_resync_d;
    out_drop_q   <= out_drop_d;
    out_reord_q  <= out_reord_d;
    out_last_q   <= out_last_d;
  end

  assign s_axis_tready = (state_q == rjb_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_reord_q, out_drop_q, out_resync_q, out_slot_q, out_seq_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // No release may be pending once the sequencer is back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rjb_pkg::S_IDLE) |-> !pend_q)
    else $error("release left pending in idle");

  // The release count never passes the per-packet limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MaxRel)
    else $error("release count beyond limit");

  // The drop counter moves only on a decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop_q != $past(drop_q)) |-> ($past(state_q) == rjb_pkg::S_DECIDE))
    else $error("drop counter changed outside a decision");

  // A result goes out only when the sequencer ends a packet or passes on a release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rjb_pkg::S_FINAL ||
                            $past(state_q) == rjb_pkg::S_CHECK))
    else $error("result loaded outside a result state");

endmodule

// ===== tb/rtp_reorder_jitter_buffer_tb.sv =====
// Self-checking testbench for the RTP reorder jitter buffer: directed and random packet streams.
`timescale 1ns / 1ps

module rtp_reorder_jitter_buffer_tb;

  localparam int unsigned Depth = 32;
  localparam int HalfWindow = Depth / 2;
  // Length of the one long receiver stall that backs the block up into its input.
  localparam int HoldCycles = 300;

  // One result as it leaves the block, unpacked into its fields.
  typedef struct {
    rjb_pkg::status_e status;
    logic [15:0] rel_seq;
    logic [4:0]  rel_slot;
    logic        resynced;
    logic [31:0] drops;
    logic [31:0] reorders;
    logic        last;
  } pkt_result_t;

  // The scoreboard keeps its own copy of the sequencer state. Every accepted
  // packet is run through that copy, and the results it yields wait in a queue
  // until the block delivers the matching transactions on the master side.
  class rjb_scoreboard;
    logic [15:0] expected_seq;
    bit          slot_valid[Depth];
    logic [15:0] slot_seq[Depth];
    logic [31:0] drop_count;
    logic [31:0] reorder_count;
    pkt_result_t release_q[$];
    int          errors;

    function new();
      expected_seq = '0;
      drop_count = '0;
      reorder_count = '0;
      errors = 0;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_seq[i] = '0;
      end
    endfunction

    // A register write loads the expected sequence; valid marks are kept.
    function void load_initial(logic [15:0] value);
      expected_seq = value;
    endfunction

    function int pending();
      return release_q.size();
    endfunction

    function void push_result(rjb_pkg::status_e st, logic [15:0] sq, logic [4:0] sl, bit rs,
                              bit lst);
      pkt_result_t r;
      r.status = st;
      r.rel_seq = sq;
      r.rel_slot = sl;
      r.resynced = rs;
      r.drops = drop_count;
      r.reorders = reorder_count;
      r.last = lst;
      release_q.push_back(r);
    endfunction

    // Works out every result that one accepted packet causes.
    function void note_packet(logic [15:0] seq, logic [15:0] bytes);
      logic signed [15:0] delta;
      int d;
      bit resync;
      int n;
      int unsigned idx;
      if (bytes < rjb_pkg::MinBytes) begin
        push_result(rjb_pkg::STATUS_SHORT, '0, '0, 1'b0, 1'b1);
        return;
      end
      delta = seq - expected_seq;
      d = delta;
      if (d < -HalfWindow) begin
        drop_count++;
        push_result(rjb_pkg::STATUS_TOO_OLD, '0, '0, 1'b0, 1'b1);
        return;
      end
      resync = 1'b0;
      if (d > HalfWindow) begin
        // Too far ahead: restart the window at this packet and flush the store.
        expected_seq = seq;
        drop_count++;
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        resync = 1'b1;
      end
      idx = seq % Depth;
      slot_seq[idx] = seq;
      slot_valid[idx] = 1'b1;
      // The out-of-order test uses the difference from before any resync.
      if (seq != expected_seq && d > 0) reorder_count++;
      n = 0;
      idx = expected_seq % Depth;
      while (n < rjb_pkg::MaxResults && slot_valid[idx] && slot_seq[idx] == expected_seq) begin
        slot_valid[idx] = 1'b0;
        push_result(rjb_pkg::STATUS_RELEASED, expected_seq, idx[4:0], resync, 1'b0);
        n++;
        expected_seq = expected_seq + 16'd1;
        idx = expected_seq % Depth;
      end
      if (n == 0) push_result(rjb_pkg::STATUS_STORED, '0, '0, resync, 1'b1);
      else release_q[release_q.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Compares one delivered result with the oldest one still waiting.
    function void check_result(pkt_result_t got);
      pkt_result_t want;
      if (release_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d seq %0h last %0b",
                 $time, got.status, got.rel_seq, got.last);
        return;
      end
      want = release_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("release_seq", want.rel_seq, got.rel_seq);
      check_field("release_slot", want.rel_slot, got.rel_slot);
      check_field("resynced", want.resynced, got.resynced);
      check_field("dropped_total", want.drops, got.drops);
      check_field("out_of_order_total", want.reorders, got.reorders);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rjb_scoreboard sb;
  pkt_result_t   seen;
  // calm switches off idling on both sides for the final part of the run.
  bit            calm;
  // hold_req asks the receiver for one long stall; the receiver clears it when done.
  bit            hold_req;

  rtp_reorder_jitter_buffer #(
    .DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run. The slowest legal run, with every packet releasing
  // the most results and every result waiting out the longest stall, stays well
  // below a quarter of this.
  initial begin
    #15_000_000;
    $display("rtp_reorder_jitter_buffer_tb failed");
    $finish;
  end

  // Results are sampled at the rising edge, before the block updates its outputs.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.status = rjb_pkg::status_e'(m_axis_tuser);
      seen.rel_seq = m_axis_tdata[15:0];
      seen.rel_slot = m_axis_tdata[20:16];
      seen.resynced = m_axis_tdata[21];
      seen.drops = m_axis_tdata[53:22];
      seen.reorders = m_axis_tdata[85:54];
      seen.last = m_axis_tlast;
      sb.check_result(seen);
    end
  end

  // Receiver: alternates stretches of readiness with random stall bursts,
  // and serves the one long hold-off when the main process asks for it.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(negedge clk_i);
      end
    end
  end

  // Offers one packet and returns once the block has taken the transaction,
  // sometimes followed by an idle gap.
  task automatic send_packet(input logic [15:0] seq, input logic [15:0] bytes);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bytes, seq};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet(seq, bytes);
    if (!calm && $urandom_range(0, 2) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
  endtask

  // Stops offering packets and waits until every predicted result has arrived.
  // Every packet yields at least one result, so the block is idle afterwards.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_initial(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_initial(value);
  endtask

  // Random traffic. Most of it is runs of consecutive sequence numbers from the
  // current expected one, shuffled and sometimes with a packet lost, so that the
  // store fills and releases chains. The rest is short packets, arbitrary
  // sequence numbers, packets near the window edges and jumps that mostly resync.
  task automatic run_random(input int count);
    logic [15:0] burst[17];
    logic [15:0] base;
    logic [15:0] tmp;
    int sent;
    int pick;
    int k;
    int j;
    int lost;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        k = $urandom_range(1, 17);
        base = sb.expected_seq;
        for (int i = 0; i < k; i++) burst[i] = base + 16'(i);
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = burst[i];
          burst[i] = burst[j];
          burst[j] = tmp;
        end
        lost = (k > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(0, k - 1) : -1;
        for (int i = 0; i < k; i++) begin
          if (i != lost) begin
            send_packet(burst[i], 16'($urandom_range(12, 65535)));
            sent++;
          end
        end
      end else if (pick < 75) begin
        // Short packets are ignored and do not count toward the total.
        send_packet(16'($urandom), 16'($urandom_range(0, 11)));
      end else if (pick < 85) begin
        send_packet(16'($urandom), 16'($urandom_range(12, 65535)));
        sent++;
      end else if (pick < 93) begin
        send_packet(sb.expected_seq + 16'($urandom_range(0, 40)) - 16'd20,
                    16'($urandom_range(12, 65535)));
        sent++;
      end else begin
        send_packet(sb.expected_seq + 16'($urandom_range(17, 40000)),
                    16'($urandom_range(12, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, started just below the sequence wrap.
    write_initial(16'hFFF0);
    send_packet(16'hFFF0, 16'd0);       // short packet, empty
    send_packet(16'hFFF0, 16'd11);      // short packet, one byte under the limit
    send_packet(16'hFFF0, 16'd12);      // in order, released at once
    send_packet(16'hFFF3, 16'hFFFF);    // ahead: stored and counted out of order
    send_packet(16'hFFF2, 16'd12);      // ahead: stored
    send_packet(16'hFFF1, 16'd200);     // fills the gap, releases three packets
    send_packet(16'hFFE3, 16'd100);     // one past the old edge: dropped
    send_packet(16'hFFE4, 16'd100);     // on the old edge: stored anyway
    send_packet(16'h0004, 16'd100);     // on the far edge across the wrap: stored
    send_packet(16'h0005, 16'd100);     // one past the far edge: resync
    send_packet(16'h0000, 16'd100);     // behind the new window start: stored
    send_packet(16'h0006, 16'hFFFF);    // in order
    send_packet(16'hFFFF, 16'd12);      // largest sequence number, behind
    for (int i = 8; i <= 17; i++) send_packet(16'(i), 16'd64);
    send_packet(16'h0007, 16'd64);      // releases a chain of eleven
    wait_drained();

    // Random phases at several starting sequences. The first one carries the
    // long receiver stall, so the block backs up and stalls its input.
    write_initial(16'hFFFF);
    run_random(40);
    hold_req = 1'b1;
    run_random(70);
    wait_drained();

    write_initial(16'h0000);
    run_random(110);
    wait_drained();

    write_initial(16'($urandom));
    run_random(110);
    wait_drained();

    // Final phase without idling on either side.
    calm = 1'b1;
    write_initial(16'($urandom));
    run_random(110);
    wait_drained();

    // Any stray result in this window is reported by the monitor.
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rtp_reorder_jitter_buffer_tb passed");
    end else begin
      $display("rtp_reorder_jitter_buffer_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rjb_pkg.sv
rtl/core/rjb_slot_mod.sv
rtl/core/rjb_slot_store.sv
rtl/core/rtp_reorder_jitter_buffer.sv
tb/rtp_reorder_jitter_buffer_tb.sv
